// ----- sv/ps2_mouse_cursor_tracker_assert.svh -----
// Assertion macros shared by the cursor tracker modules.
`ifndef PS2_MOUSE_CURSOR_TRACKER_ASSERT_SVH
`define PS2_MOUSE_CURSOR_TRACKER_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define PS2MCT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ps2mct: assertion failed");

// Next-cycle implication, checked out of reset.
`define PS2MCT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ps2mct: assertion failed");

`endif

// ----- sv/ps2mct_pkg.sv -----
// Shared types and constants for the PS/2 mouse cursor tracker.
package ps2mct_pkg;

  localparam int OUT_BITS        = 12;
  localparam int COORD_BITS_DEF  = 12;
  localparam int EXT_BITS        = 13;
  localparam int LEN_BITS        = 3;
  localparam int CFG_IDX_BITS    = 2;
  localparam int QUEUE_DEPTH     = 2;

  localparam logic [EXT_BITS-1:0] WIDTH_RST  = 13'd1024;
  localparam logic [EXT_BITS-1:0] HEIGHT_RST = 13'd768;
  localparam logic [LEN_BITS-1:0] PKT_STD    = 3'd3;
  localparam logic [LEN_BITS-1:0] PKT_WHEEL  = 3'd4;

  // Configuration register indexes.
  localparam logic [CFG_IDX_BITS-1:0] CFG_SCREEN_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SCREEN_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_PACKET_BYTES  = 2'd2;

  // One assembled packet, as queued between front and back.
  typedef struct packed {
    logic [2:0] buttons;   // middle, right, left
    logic [7:0] dx;
    logic [7:0] dy;
    logic [7:0] wheel;
  } pkt_t;

  // Screen extents seen by the back end.
  typedef struct packed {
    logic [EXT_BITS-1:0] width;
    logic [EXT_BITS-1:0] height;
  } ext_cfg_t;

endpackage

// ----- sv/ps2mct_front.sv -----
// Byte gatherer: assembles mouse bytes into packets and pushes them to the queue.
module ps2mct_front (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [7:0]                           in_rx_byte,
  input  logic [ps2mct_pkg::LEN_BITS-1:0]      packet_bytes,
  input  logic                                 q_ready,
  output logic                                 q_push,
  output ps2mct_pkg::pkt_t                     q_pkt
);

  logic [1:0] cnt_r, cnt_nxt;
  logic [2:0] hdr_r;
  logic [7:0] dx_r;
  logic [7:0] dy_r;
  logic       len4;
  logic       done;
  logic       accept;

  assign in_ready = q_ready;
  assign accept   = in_valid & in_ready;
  assign len4     = (packet_bytes == ps2mct_pkg::PKT_WHEEL);
  // A packet closes on its last byte: count 3 for four-byte packets, count 2 or more otherwise.
  assign done     = len4 ? (cnt_r == 2'd3) : (cnt_r >= 2'd2);
  assign q_push   = accept & done;

  always_comb begin
    q_pkt.buttons = hdr_r;
    q_pkt.dx      = dx_r;
    q_pkt.dy      = (cnt_r == 2'd2) ? in_rx_byte : dy_r;
    q_pkt.wheel   = (len4 && cnt_r == 2'd3) ? in_rx_byte : 8'd0;
    cnt_nxt       = cnt_r;
    if (accept) begin
      cnt_nxt = done ? 2'd0 : cnt_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      case (cnt_r)
        2'd0:    hdr_r <= in_rx_byte[2:0];
        2'd1:    dx_r  <= in_rx_byte;
        2'd2:    dy_r  <= in_rx_byte;
        default: ;
      endcase
    end
  end

endmodule

// ----- sv/ps2mct_queue.sv -----
// Small packet queue between the byte gatherer and the cursor update.
`include "ps2_mouse_cursor_tracker_assert.svh"

module ps2mct_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  ps2mct_pkg::pkt_t  push_pkt,
  output logic              ready,
  input  logic              pop,
  output logic              valid,
  output ps2mct_pkg::pkt_t  head_pkt
);

  localparam int DEPTH = ps2mct_pkg::QUEUE_DEPTH;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);

  ps2mct_pkg::pkt_t mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  assign ready    = (count_r != FULL_CNT);
  assign valid    = (count_r != '0);
  assign head_pkt = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_pkt;
    end
  end

  `PS2MCT_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1, count_r <= FULL_CNT)
  `PS2MCT_ASSERT_NOW(a_pop_nonempty, clk, rst_n, pop, count_r != '0)
  `PS2MCT_ASSERT_NEXT(a_push_grows, clk, rst_n, push && !pop, count_r == $past(count_r) + 1'b1)

endmodule

// ----- sv/ps2mct_back.sv -----
// Cursor update: applies queued packets to the clamped position and registers results.
`include "ps2_mouse_cursor_tracker_assert.svh"

module ps2mct_back #(
  parameter int COORD_BITS = ps2mct_pkg::COORD_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  ps2mct_pkg::ext_cfg_t                 ext_cfg,
  input  logic                                 q_valid,
  input  ps2mct_pkg::pkt_t                     q_pkt,
  output logic                                 q_pop,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [ps2mct_pkg::OUT_BITS-1:0]      out_cursor_x,
  output logic [ps2mct_pkg::OUT_BITS-1:0]      out_cursor_y,
  output logic                                 out_left_button,
  output logic                                 out_right_button,
  output logic                                 out_middle_button,
  output logic signed [7:0]                    out_wheel_delta
);

  localparam int OB    = ps2mct_pkg::OUT_BITS;
  localparam int POS_W = (COORD_BITS > OB) ? COORD_BITS : OB;
  localparam int EW    = (COORD_BITS + 1 > ps2mct_pkg::EXT_BITS) ?
                         COORD_BITS + 1 : ps2mct_pkg::EXT_BITS;
  localparam logic [EW-1:0]    ELIMIT = EW'(1) << COORD_BITS;
  localparam logic [POS_W-1:0] X_RST  = POS_W'(ps2mct_pkg::WIDTH_RST >> 1);
  localparam logic [POS_W-1:0] Y_RST  = POS_W'(ps2mct_pkg::HEIGHT_RST >> 1);

  // Largest coordinate for an extent: zero acts as one, large saturates.
  function automatic logic [POS_W-1:0] axis_top(input logic [ps2mct_pkg::EXT_BITS-1:0] ext);
    logic [EW-1:0] e;
    e = EW'(ext);
    if (e == '0) begin
      e = EW'(1);
    end
    if (e > ELIMIT) begin
      e = ELIMIT;
    end
    return POS_W'(e - EW'(1));
  endfunction

  function automatic logic [POS_W-1:0] step_axis(input logic [POS_W-1:0] pos,
                                                  input logic signed [8:0] d,
                                                  input logic [POS_W-1:0] top);
    logic signed [POS_W+1:0] p;
    p = $signed({2'b00, pos}) + $signed({{(POS_W-7){d[8]}}, d});
    if (p < 0) begin
      return '0;
    end else if (p > $signed({2'b00, top})) begin
      return top;
    end
    return p[POS_W-1:0];
  endfunction

  logic [POS_W-1:0]  pos_x_r, pos_x_nxt;
  logic [POS_W-1:0]  pos_y_r, pos_y_nxt;
  logic [POS_W-1:0]  x_top, y_top;
  logic signed [8:0] dx_s, dy_neg;
  logic              out_valid_r, out_valid_nxt;
  logic [OB-1:0]     cursor_x_r, cursor_y_r;
  logic [2:0]        buttons_r;
  logic [7:0]        wheel_r;

  assign x_top  = axis_top(ext_cfg.width);
  assign y_top  = axis_top(ext_cfg.height);
  assign dx_s   = $signed({q_pkt.dx[7], q_pkt.dx});
  // Moving up is positive and lowers Y.
  assign dy_neg = 9'sd0 - $signed({q_pkt.dy[7], q_pkt.dy});
  assign q_pop  = q_valid & (~out_valid_r | out_ready);

  always_comb begin
    pos_x_nxt     = pos_x_r;
    pos_y_nxt     = pos_y_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    if (q_pop) begin
      pos_x_nxt     = step_axis(pos_x_r, dx_s, x_top);
      pos_y_nxt     = step_axis(pos_y_r, dy_neg, y_top);
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_x_r     <= X_RST;
      pos_y_r     <= Y_RST;
      out_valid_r <= 1'b0;
    end else begin
      pos_x_r     <= pos_x_nxt;
      pos_y_r     <= pos_y_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cursor_x_r <= pos_x_nxt[OB-1:0];
      cursor_y_r <= pos_y_nxt[OB-1:0];
      buttons_r  <= q_pkt.buttons;
      wheel_r    <= q_pkt.wheel;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_cursor_x      = cursor_x_r;
  assign out_cursor_y      = cursor_y_r;
  assign out_left_button   = buttons_r[0];
  assign out_right_button  = buttons_r[1];
  assign out_middle_button = buttons_r[2];
  assign out_wheel_delta   = $signed(wheel_r);

  `PS2MCT_ASSERT_NOW(a_x_in_range, clk, rst_n, out_valid_r, pos_x_r <= x_top)
  `PS2MCT_ASSERT_NOW(a_y_in_range, clk, rst_n, out_valid_r, pos_y_r <= y_top)

endmodule

// ----- sv/ps2_mouse_cursor_tracker.sv -----
// Top level of the PS/2 mouse cursor tracker: config registers and the three stages.
//
// Input channel (in_valid/in_ready/in_rx_byte): one mouse byte per item. Bytes
// gather into packets of three (header, X, Y) or four (plus wheel) as set by
// packet_bytes. Only the byte that closes a packet produces a result.
// Result channel (out_valid/out_ready/out_*): clamped cursor position, three
// button bits from the header, and the signed wheel delta (zero unless a
// four-byte packet supplied it).
// Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data): index 0 screen
// width, 1 screen height, 2 packet bytes; other indexes are dropped. Always
// ready. Write only while no packet is in flight.
// Throughput: one byte per cycle while the queue has room. The closing byte
// writes the packet into the queue; the result registers load when the back
// end pops it, which waits while a held result has not yet been taken.
// Reset: byte count cleared, width 1024, height 768, three-byte packets,
// cursor centered at 512,384.
// Stall: when out_ready is low the result register holds; completed packets
// collect in the two-entry queue, and in_ready drops once it is full.
module ps2_mouse_cursor_tracker #(
  parameter int COORD_BITS = ps2mct_pkg::COORD_BITS_DEF
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     in_valid,
  output logic                                     in_ready,
  input  logic [7:0]                               in_rx_byte,
  output logic                                     out_valid,
  input  logic                                     out_ready,
  output logic [ps2mct_pkg::OUT_BITS-1:0]          out_cursor_x,
  output logic [ps2mct_pkg::OUT_BITS-1:0]          out_cursor_y,
  output logic                                     out_left_button,
  output logic                                     out_right_button,
  output logic                                     out_middle_button,
  output logic signed [7:0]                        out_wheel_delta,
  input  logic                                     cfg_valid,
  output logic                                     cfg_ready,
  input  logic [ps2mct_pkg::CFG_IDX_BITS-1:0]      cfg_index,
  input  logic [ps2mct_pkg::EXT_BITS-1:0]          cfg_data
);

  ps2mct_pkg::ext_cfg_t                ext_cfg_r;
  logic [ps2mct_pkg::LEN_BITS-1:0]     pkt_bytes_r;
  logic                                cfg_we;

  logic                                q_push, q_ready, q_pop, q_valid;
  ps2mct_pkg::pkt_t                    push_pkt, head_pkt;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid & cfg_ready;

  // Hold the configuration; writes to unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ext_cfg_r.width  <= ps2mct_pkg::WIDTH_RST;
      ext_cfg_r.height <= ps2mct_pkg::HEIGHT_RST;
      pkt_bytes_r      <= ps2mct_pkg::PKT_STD;
    end else if (cfg_we) begin
      case (cfg_index)
        ps2mct_pkg::CFG_SCREEN_WIDTH:  ext_cfg_r.width  <= cfg_data;
        ps2mct_pkg::CFG_SCREEN_HEIGHT: ext_cfg_r.height <= cfg_data;
        ps2mct_pkg::CFG_PACKET_BYTES:  pkt_bytes_r      <= cfg_data[ps2mct_pkg::LEN_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Front: gather bytes into packets.
  ps2mct_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_rx_byte   (in_rx_byte),
    .packet_bytes (pkt_bytes_r),
    .q_ready      (q_ready),
    .q_push       (q_push),
    .q_pkt        (push_pkt)
  );

  // Queue: decouple packet assembly from the result handshake.
  ps2mct_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_pkt (push_pkt),
    .ready    (q_ready),
    .pop      (q_pop),
    .valid    (q_valid),
    .head_pkt (head_pkt)
  );

  // Back: advance the cursor and present the result.
  ps2mct_back #(
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .ext_cfg           (ext_cfg_r),
    .q_valid           (q_valid),
    .q_pkt             (head_pkt),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_cursor_x      (out_cursor_x),
    .out_cursor_y      (out_cursor_y),
    .out_left_button   (out_left_button),
    .out_right_button  (out_right_button),
    .out_middle_button (out_middle_button),
    .out_wheel_delta   (out_wheel_delta)
  );

endmodule
